@@ src/rcsr_pkg.sv @@
`default_nettype none
package rcsr_pkg;

  localparam int CHANNELS = 256;
  localparam int CH_W = $clog2(CHANNELS);
  localparam logic [23:0] TS_EXTENDED = 24'hFFFFFF;
  localparam logic [16:0] CH_EXT_BASE = 17'd64;
  localparam logic [16:0] CH_LIMIT = 17'(CHANNELS);
  localparam logic [23:0] MAX_CHUNK_RESET = 24'd128;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_RANGE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FMT_FULL  = 2'd0,
    FMT_NOSID = 2'd1,
    FMT_TSONLY = 2'd2,
    FMT_NONE  = 2'd3
  } fmt_t;

  typedef enum logic [9:0] {
    PH_BASIC  = 10'b0000000001,
    PH_CH1    = 10'b0000000010,
    PH_CH2    = 10'b0000000100,
    PH_TS     = 10'b0000001000,
    PH_SIZE   = 10'b0000010000,
    PH_TYPE   = 10'b0000100000,
    PH_STREAM = 10'b0001000000,
    PH_EXT    = 10'b0010000000,
    PH_DATA   = 10'b0100000000,
    PH_LOOKUP = 10'b1000000000
  } phase_t;

  typedef struct packed {
    logic        busy;
    logic [23:0] size;
    logic [7:0]  msg_type;
    logic [31:0] stream;
    logic [23:0] ts_hdr;
    logic [31:0] ts;
    logic [23:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_t       kind;
    logic [16:0] channel;
    logic [7:0]  msg_type;
    logic [31:0] stream_id;
    logic [31:0] timestamp;
    logic [23:0] msg_length;
    logic [23:0] offset;
    logic [7:0]  data;
    logic        chunk_last;
    logic        msg_last;
  } res_t;

endpackage
`default_nettype wire

@@ src/rcsr_ram.sv @@
`default_nettype none
module rcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/rcsr_parser.sv @@
`default_nettype none
module rcsr_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_byte,
  input  wire logic [23:0]      max_chunk,
  input  wire logic             full,
  output logic                  push,
  output rcsr_pkg::res_t        res
);

  rcsr_pkg::phase_t phase, phase_next;
  logic [2:0]  field_count, field_count_next;
  logic [1:0]  hdr_fmt, hdr_fmt_next;
  logic [16:0] cur_channel, cur_channel_next;
  logic [31:0] assemble_reg, assemble_reg_next;
  logic [23:0] chunk_left, chunk_left_next;
  logic [23:0] lat_ts, lat_ts_next;
  logic [23:0] lat_size, lat_size_next;
  logic [7:0]  lat_type, lat_type_next;
  logic [31:0] lat_stream, lat_stream_next;
  rcsr_pkg::entry_t ent, ent_next;
  logic load_q, load_q_next;

  logic [rcsr_pkg::CHANNELS-1:0] valid;
  logic vld_q;
  logic [rcsr_pkg::ENTRY_W-1:0] rdata;
  rcsr_pkg::entry_t ld, cur, wentry, fin;
  logic we;
  logic [rcsr_pkg::CH_W-1:0] ridx;
  logic [16:0] ch_new;
  logic acc, step;

  logic [31:0] asm_sh, asm_or, tsv, ts_new;
  logic [23:0] lts_now, lsize_now, remain, lim, cl;
  logic [7:0]  ltype_now;
  logic [31:0] lstream_now;
  logic [23:0] off_inc, left_dec;
  logic mism;

  assign in_stall = full || (phase == rcsr_pkg::PH_LOOKUP);
  assign acc = in_valid && !in_stall;
  assign step = acc || (phase == rcsr_pkg::PH_LOOKUP && !full);

  rcsr_ram #(.WIDTH(rcsr_pkg::ENTRY_W), .DEPTH(rcsr_pkg::CHANNELS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (cur_channel[rcsr_pkg::CH_W-1:0]),
    .wdata (wentry),
    .raddr (ridx),
    .rdata (rdata)
  );

  assign ridx = ch_new[rcsr_pkg::CH_W-1:0];
  // entries never written since reset read as zero
  assign ld  = vld_q ? rcsr_pkg::entry_t'(rdata) : '0;
  assign cur = load_q ? ld : ent;

  assign asm_sh = {assemble_reg[23:0], in_byte};
  assign asm_or = assemble_reg | ({24'd0, in_byte} << {field_count[1:0], 3'd0});

  always_comb begin
    case (phase)
      rcsr_pkg::PH_BASIC: ch_new = {11'd0, in_byte[5:0]};
      rcsr_pkg::PH_CH1:   ch_new = {9'd0, in_byte} + rcsr_pkg::CH_EXT_BASE;
      default:            ch_new = {1'b0, in_byte, assemble_reg[7:0]} + rcsr_pkg::CH_EXT_BASE;
    endcase
  end

  // header fields as they stand once the current byte is taken
  always_comb begin
    lts_now     = (phase == rcsr_pkg::PH_TS) ? asm_sh[23:0]
                : (load_q ? ld.ts_hdr : lat_ts);
    lsize_now   = load_q ? ld.size : lat_size;
    ltype_now   = (phase == rcsr_pkg::PH_TYPE) ? in_byte
                : (load_q ? ld.msg_type : lat_type);
    lstream_now = (phase == rcsr_pkg::PH_STREAM) ? asm_or
                : (load_q ? ld.stream : lat_stream);
    tsv    = (phase == rcsr_pkg::PH_EXT) ? asm_sh : {8'd0, lts_now};
    ts_new = (hdr_fmt != rcsr_pkg::FMT_FULL) ? tsv + cur.ts : tsv;
    mism   = cur.busy && (lsize_now != cur.size);
    fin.busy     = cur.busy;
    fin.size     = lsize_now;
    fin.msg_type = ltype_now;
    fin.stream   = lstream_now;
    fin.ts_hdr   = cur.busy ? cur.ts_hdr : lts_now;
    fin.ts       = cur.busy ? cur.ts : ts_new;
    fin.offset   = cur.busy ? cur.offset : 24'd0;
    remain = fin.size - fin.offset;
    lim    = (max_chunk == 24'd0) ? 24'd1 : max_chunk;
    cl     = (remain < lim) ? remain : lim;
    off_inc  = ent.offset + 24'd1;
    left_dec = chunk_left - 24'd1;
  end

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    hdr_fmt_next      = hdr_fmt;
    cur_channel_next  = cur_channel;
    assemble_reg_next = assemble_reg;
    chunk_left_next   = chunk_left;
    lat_ts_next       = load_q ? ld.ts_hdr : lat_ts;
    lat_size_next     = load_q ? ld.size : lat_size;
    lat_type_next     = load_q ? ld.msg_type : lat_type;
    lat_stream_next   = load_q ? ld.stream : lat_stream;
    ent_next          = cur;
    load_q_next       = 1'b0;
    we     = 1'b0;
    wentry = cur;
    push   = 1'b0;
    res    = '0;
    if (step) begin
      logic known, finish, after;
      known  = 1'b0;
      finish = 1'b0;
      after  = 1'b0;
      case (phase)
        rcsr_pkg::PH_BASIC: begin
          hdr_fmt_next      = in_byte[7:6];
          assemble_reg_next = '0;
          field_count_next  = '0;
          if (in_byte[5:0] == 6'd0) begin
            phase_next = rcsr_pkg::PH_CH1;
          end else if (in_byte[5:0] == 6'd1) begin
            phase_next = rcsr_pkg::PH_CH2;
          end else begin
            known = 1'b1;
          end
        end
        rcsr_pkg::PH_CH1: known = 1'b1;
        rcsr_pkg::PH_CH2: begin
          if (field_count == 3'd0) begin
            assemble_reg_next = {24'd0, in_byte};
            field_count_next  = 3'd1;
          end else begin
            known = 1'b1;
          end
        end
        rcsr_pkg::PH_TS: begin
          if (field_count + 3'd1 < 3'd3) begin
            assemble_reg_next = asm_sh;
            field_count_next  = field_count + 3'd1;
          end else begin
            lat_ts_next       = asm_sh[23:0];
            field_count_next  = '0;
            assemble_reg_next = '0;
            if (hdr_fmt == rcsr_pkg::FMT_TSONLY) begin
              after = 1'b1;
            end else begin
              phase_next = rcsr_pkg::PH_SIZE;
            end
          end
        end
        rcsr_pkg::PH_SIZE: begin
          assemble_reg_next = asm_sh;
          field_count_next  = field_count + 3'd1;
          if (field_count + 3'd1 >= 3'd3) begin
            lat_size_next = asm_sh[23:0];
            phase_next    = rcsr_pkg::PH_TYPE;
          end
        end
        rcsr_pkg::PH_TYPE: begin
          lat_type_next     = in_byte;
          field_count_next  = '0;
          assemble_reg_next = '0;
          if (hdr_fmt == rcsr_pkg::FMT_NOSID) begin
            after = 1'b1;
          end else begin
            phase_next = rcsr_pkg::PH_STREAM;
          end
        end
        rcsr_pkg::PH_STREAM: begin
          assemble_reg_next = asm_or;
          field_count_next  = field_count + 3'd1;
          if (field_count + 3'd1 >= 3'd4) begin
            lat_stream_next = asm_or;
            after = 1'b1;
          end
        end
        rcsr_pkg::PH_EXT: begin
          assemble_reg_next = asm_sh;
          field_count_next  = field_count + 3'd1;
          if (field_count + 3'd1 >= 3'd4) begin
            finish = 1'b1;
          end
        end
        rcsr_pkg::PH_LOOKUP: begin
          lat_ts_next = lts_now;
          after = 1'b1;
        end
        rcsr_pkg::PH_DATA: begin
          ent_next.offset = off_inc;
          chunk_left_next = left_dec;
          push = 1'b1;
          res.kind       = rcsr_pkg::KIND_DATA;
          res.channel    = cur_channel;
          res.msg_type   = ent.msg_type;
          res.stream_id  = ent.stream;
          res.timestamp  = ent.ts;
          res.msg_length = ent.size;
          res.offset     = ent.offset;
          res.data       = in_byte;
          if (left_dec == 24'd0) begin
            phase_next      = rcsr_pkg::PH_BASIC;
            res.chunk_last  = 1'b1;
            res.msg_last    = (off_inc == ent.size);
            ent_next.busy   = (off_inc != ent.size);
            we     = 1'b1;
            wentry = ent_next;
          end
        end
        default: phase_next = rcsr_pkg::PH_BASIC;
      endcase

      if (known) begin
        cur_channel_next = ch_new;
        if (ch_new >= rcsr_pkg::CH_LIMIT) begin
          phase_next  = rcsr_pkg::PH_BASIC;
          push        = 1'b1;
          res.kind    = rcsr_pkg::KIND_RANGE;
          res.channel = ch_new;
        end else begin
          load_q_next       = 1'b1;
          field_count_next  = '0;
          assemble_reg_next = '0;
          phase_next = (hdr_fmt_next == rcsr_pkg::FMT_NONE) ? rcsr_pkg::PH_LOOKUP
                                                            : rcsr_pkg::PH_TS;
        end
      end

      if (after) begin
        if (lts_now == rcsr_pkg::TS_EXTENDED) begin
          phase_next        = rcsr_pkg::PH_EXT;
          field_count_next  = '0;
          assemble_reg_next = '0;
        end else begin
          finish = 1'b1;
        end
      end

      if (finish) begin
        phase_next = rcsr_pkg::PH_BASIC;
        we = 1'b1;
        if (mism) begin
          wentry      = cur;
          wentry.busy = 1'b0;
          wentry.size = '0;
          ent_next    = wentry;
          push        = 1'b1;
          res.kind       = rcsr_pkg::KIND_MISMATCH;
          res.channel    = cur_channel;
          res.msg_length = lsize_now;
        end else begin
          wentry          = fin;
          ent_next        = fin;
          chunk_left_next = cl;
          if (cl == 24'd0) begin
            push = 1'b1;
            res.kind      = rcsr_pkg::KIND_EMPTY;
            res.channel   = cur_channel;
            res.msg_type  = fin.msg_type;
            res.stream_id = fin.stream;
            res.timestamp = fin.ts;
          end else begin
            phase_next = rcsr_pkg::PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= rcsr_pkg::PH_BASIC;
      load_q <= 1'b0;
      valid  <= '0;
      field_count <= '0;
      hdr_fmt     <= '0;
    end else begin
      phase  <= phase_next;
      load_q <= load_q_next;
      field_count <= field_count_next;
      hdr_fmt     <= hdr_fmt_next;
      if (we) begin
        valid[cur_channel[rcsr_pkg::CH_W-1:0]] <= 1'b1;
      end
    end
    vld_q        <= valid[ridx];
    cur_channel  <= cur_channel_next;
    assemble_reg <= assemble_reg_next;
    chunk_left   <= chunk_left_next;
    lat_ts       <= lat_ts_next;
    lat_size     <= lat_size_next;
    lat_type     <= lat_type_next;
    lat_stream   <= lat_stream_next;
    ent          <= ent_next;
  end

endmodule
`default_nettype wire

@@ src/rcsr_outbuf.sv @@
`default_nettype none
module rcsr_outbuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rcsr_pkg::res_t pdata,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rcsr_pkg::res_t      out
);

  logic skid_valid;
  rcsr_pkg::res_t skid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out        <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out       <= pdata;
      end
    end else if (push) begin
      skid       <= pdata;
      skid_valid <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds an item while output is empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid) else $error("item pushed into full buffer");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !skid_valid && !push) |=> !out_valid)
    else $error("output item repeated");
`endif

endmodule
`default_nettype wire

@@ src/rtmp_chunk_stream_reader_top.sv @@
// channel  handshake                    payload
// input    in_valid / in_stall          in_byte
// output   out_valid / out_stall        kind channel msg_type stream_id timestamp
//                                       msg_length offset data chunk_last msg_last
// config   APB psel penable pwrite      paddr pwdata prdata pready (max chunk @ 0)
//
// One byte per cycle while in_stall is low. A fmt 3 chunk stalls input once its
// channel is known, for the channel table read (one read port, registered read).
// Results pass through an output register and a skid stage; apart from that
// lookup stall, input stalls only while both hold an item. Reset is synchronous;
// table entries carry valid bits cleared at reset, so no clearing pass is needed.
`default_nettype none
module rtmp_chunk_stream_reader_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [16:0]      channel,
  output logic [7:0]       msg_type,
  output logic [31:0]      stream_id,
  output logic [31:0]      timestamp,
  output logic [23:0]      msg_length,
  output logic [23:0]      offset,
  output logic [7:0]       data,
  output logic             chunk_last,
  output logic             msg_last
);

  logic [23:0] max_chunk;
  logic push, full;
  rcsr_pkg::res_t pres, ores;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {8'd0, max_chunk} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk <= rcsr_pkg::MAX_CHUNK_RESET;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      max_chunk <= pwdata[23:0];
    end
  end

  rcsr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .max_chunk  (max_chunk),
    .full       (full),
    .push       (push),
    .res        (pres)
  );

  rcsr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pdata     (pres),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out       (ores)
  );

  assign kind       = ores.kind;
  assign channel    = ores.channel;
  assign msg_type   = ores.msg_type;
  assign stream_id  = ores.stream_id;
  assign timestamp  = ores.timestamp;
  assign msg_length = ores.msg_length;
  assign offset     = ores.offset;
  assign data       = ores.data;
  assign chunk_last = ores.chunk_last;
  assign msg_last   = ores.msg_last;

endmodule
`default_nettype wire
